/* src/hbsc_pkg.sv */
// ----------------------------------------------------------------------------
// hbsc_pkg: shared types and constants for the half/bfloat/single converter
// Operation codes and field widths used by all converter files.
// ----------------------------------------------------------------------------
`default_nettype none
package hbsc_pkg;
  localparam int unsigned OpW   = 2;
  localparam int unsigned WordW = 32;

  typedef enum logic [OpW-1:0] {
    OP_HALF_TO_SINGLE = 2'd0,
    OP_SINGLE_TO_HALF = 2'd1,
    OP_BF16_TO_SINGLE = 2'd2,
    OP_SINGLE_TO_BF16 = 2'd3
  } op_t;
endpackage
`default_nettype wire

/* src/hbsc_if.sv */
// ----------------------------------------------------------------------------
// hbsc_in_if / hbsc_out_if: valid/ready channels of the converter
// Input carries operation and operand; output carries the result word.
// ----------------------------------------------------------------------------
`default_nettype none
interface hbsc_in_if;
  logic                            valid;
  logic                            ready;
  logic [hbsc_pkg::OpW-1:0]        operation;
  logic [hbsc_pkg::WordW-1:0]      operand_bits;
  modport source (output valid, output operation, output operand_bits, input ready);
  modport sink   (input valid, input operation, input operand_bits, output ready);
endinterface

interface hbsc_out_if;
  logic                            valid;
  logic                            ready;
  logic [hbsc_pkg::WordW-1:0]      result_bits;
  modport source (output valid, output result_bits, input ready);
  modport sink   (input valid, input result_bits, output ready);
endinterface
`default_nettype wire

/* src/hbsc_convert.sv */
// ----------------------------------------------------------------------------
// hbsc_convert: combinational format conversion
// Computes the result word for one operation code and operand.
// ----------------------------------------------------------------------------
`default_nettype none
module hbsc_convert (
  input  wire logic [hbsc_pkg::OpW-1:0]   operation,
  input  wire logic [hbsc_pkg::WordW-1:0] operand_bits,
  output logic      [hbsc_pkg::WordW-1:0] result_bits
);
  logic [31:0] h2s, s2h, b2s, s2b;
  logic [3:0]  lead;
  logic [9:0]  hman, nman;
  logic [4:0]  hex;
  logic [7:0]  sex;
  logic [22:0] sman;
  logic [23:0] full;
  logic [31:0] rsum;
  logic [4:0]  shamt;

  // half to single; subnormals normalized by leading-one position
  always_comb begin
    hex  = operand_bits[14:10];
    hman = operand_bits[9:0];
    lead = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hman[i]) lead = 4'(i);
    end
    nman = 10'(hman << (4'd10 - lead));
    if (hex == 5'd0) begin
      if (hman == 10'd0) h2s = {operand_bits[15], 31'd0};
      else h2s = {operand_bits[15], 8'(8'd103 + {4'd0, lead}), nman, 13'd0};
    end else if (hex == 5'd31) begin
      h2s = {operand_bits[15], 8'hFF, hman, 13'd0};
    end else begin
      h2s = {operand_bits[15], 8'({3'd0, hex} + 8'd112), hman, 13'd0};
    end
  end

  // single to half; truncating
  always_comb begin
    sex   = operand_bits[30:23];
    sman  = operand_bits[22:0];
    full  = {1'b1, sman};
    shamt = 5'(8'd126 - sex);
    s2h   = {16'd0, operand_bits[31], 15'd0};
    if (sex == 8'hFF) begin
      s2h[14:0] = {5'h1F, (sman != 23'd0), 9'd0};
    end else if (sex > 8'd142) begin
      s2h[14:0] = 15'h7C00;
    end else if (sex < 8'd113) begin
      if (sex >= 8'd102) s2h[14:0] = 15'(full >> shamt);
    end else begin
      s2h[14:0] = {5'(sex - 8'd112), sman[22:13]};
    end
  end

  // bfloat16 paths
  assign b2s  = {operand_bits[15:0], 16'd0};
  assign rsum = operand_bits + {31'd0, operand_bits[16]} + 32'h7FFF;
  assign s2b  = {16'd0, rsum[31:16]};

  always_comb begin
    case (operation)
      hbsc_pkg::OP_HALF_TO_SINGLE: result_bits = h2s;
      hbsc_pkg::OP_SINGLE_TO_HALF: result_bits = s2h;
      hbsc_pkg::OP_BF16_TO_SINGLE: result_bits = b2s;
      default:                     result_bits = s2b;
    endcase
  end
endmodule
`default_nettype wire

/* src/half_bfloat_single_converter.sv */
// Path: an accepted item enters the input register, then moves to the result register, which drives the output.
// Throughput: one item per cycle while the output is ready; the conversion logic sits between the two regs.
// Stall: each register stage holds its item while the stage after it is full and cannot take it.
// Reset: rst_n synchronous active low clears both valid flags; no other state.
// ----------------------------------------------------------------------------
// half_bfloat_single_converter: top level of the format converter
// Input register, conversion logic, result register with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
module half_bfloat_single_converter (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hbsc_in_if.sink     in_ch,
  hbsc_out_if.source  out_ch
);
  logic                           s1_vld_r;
  logic [hbsc_pkg::OpW-1:0]       s1_op_r;
  logic [hbsc_pkg::WordW-1:0]     s1_opnd_r;
  logic                           s2_vld_r;
  logic [hbsc_pkg::WordW-1:0]     s2_res_r;
  logic [hbsc_pkg::WordW-1:0]     res_nxt;
  logic                           s2_load, s1_load;

  assign s2_load     = s1_vld_r && (!s2_vld_r || out_ch.ready);
  assign s1_load     = !s1_vld_r || s2_load;
  assign in_ch.ready = s1_load;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_load) begin
      s1_vld_r <= in_ch.valid;
    end
    if (s1_load) begin
      s1_op_r   <= in_ch.operation;
      s1_opnd_r <= in_ch.operand_bits;
    end
  end

  hbsc_convert u_conv (
    .operation    (s1_op_r),
    .operand_bits (s1_opnd_r),
    .result_bits  (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_load) begin
      s2_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      s2_vld_r <= 1'b0;
    end
    if (s2_load) s2_res_r <= res_nxt;
  end

  assign out_ch.valid       = s2_vld_r;
  assign out_ch.result_bits = s2_res_r;
endmodule
`default_nettype wire

/* src/hbsc_checker.sv */
// ----------------------------------------------------------------------------
// hbsc_assert_checker: port-level assertions for the converter
// Checks output hold under stall, reset clearing, input ready and latency.
// ----------------------------------------------------------------------------
`default_nettype none
module hbsc_assert_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_result_bits
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_bits))
    else $error("result changed under stall");

  // reset clears the result valid flag
  a_after_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // with output register empty, input is ready
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // accepted item reaches the output when the sink stays ready
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after two cycles");
endmodule

bind half_bfloat_single_converter hbsc_assert_checker u_hbsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result_bits (out_ch.result_bits)
);
`default_nettype wire

/* sim/hbsc_checker.sv */
// ----------------------------------------------------------------------------
// hbsc_checker: result predictor and scoreboard for the format converter
// Watches both channels, computes the expected word for every accepted item
// and compares each accepted result with the oldest expected word.
// ----------------------------------------------------------------------------
module hbsc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_operand_bits,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_result_bits,
  output int          mismatches,
  output int          pending
);
  logic [31:0] expected_words[$];

  // half to single: normalize subnormals, pass NaN payloads through
  function automatic logic [31:0] half_to_single_word(logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [9:0]  man;
    int          lead;
    sgn = {h[15], 31'b0};
    ex  = h[14:10];
    man = h[9:0];
    if (ex == 5'd0) begin
      if (man == 10'd0) return sgn;
      lead = 9;
      while (man[lead] == 1'b0) lead--;
      man = man << (10 - lead);
      return sgn | (32'(103 + lead) << 23) | ({22'b0, man} << 13);
    end
    if (ex == 5'h1f) return sgn | 32'h7f80_0000 | ({22'b0, man} << 13);
    return sgn | (32'(ex + 112) << 23) | ({22'b0, man} << 13);
  endfunction

  // single to half: truncating narrow with overflow, subnormal and flush cases
  function automatic logic [31:0] single_to_half_word(logic [31:0] x);
    logic [31:0] sgn;
    int          ex;
    logic [31:0] man;
    sgn = {16'b0, x[31], 15'b0};
    ex  = int'(x[30:23]) - 127;
    man = {9'b0, x[22:0]};
    if (ex == 128) return sgn | 32'h7c00 | ((man != 0) ? 32'h200 : 32'h0);
    if (ex > 15) return sgn | 32'h7c00;
    if (ex < -14) begin
      if (ex < -25) return sgn;
      return sgn | ((man | 32'h80_0000) >> (-1 - ex));
    end
    return sgn | (32'(ex + 15) << 10) | (man >> 13);
  endfunction

  function automatic logic [31:0] convert_word(hbsc_pkg::op_t op, logic [31:0] v);
    logic [31:0] r;
    case (op)
      hbsc_pkg::OP_HALF_TO_SINGLE: return half_to_single_word(v[15:0]);
      hbsc_pkg::OP_SINGLE_TO_HALF: return single_to_half_word(v);
      hbsc_pkg::OP_BF16_TO_SINGLE: return {v[15:0], 16'b0};
      default: begin
        // round to nearest even with plain wraparound
        r = v + {31'b0, v[16]} + 32'h7fff;
        return {16'b0, r[31:16]};
      end
    endcase
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      mismatches <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_words.push_back(convert_word(hbsc_pkg::op_t'(in_operation),
                                              in_operand_bits));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result %08h with nothing pending", out_result_bits);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_words.pop_front();
          if (want !== out_result_bits) begin
            if (mismatches < 10)
              $display("result_bits mismatch: expected %08h got %08h", want, out_result_bits);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the half/bfloat/single converter
// Drives directed corner operands for all four conversions, then random
// operands biased toward exponent edges, with random idle bursts on both
// sides; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   cycles;
  int   sent;
  int   quiet_from;

  hbsc_in_if  in_ch();
  hbsc_out_if out_ch();

  half_bfloat_single_converter u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  hbsc_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_operation(in_ch.operation), .in_operand_bits(in_ch.operand_bits),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_result_bits(out_ch.result_bits),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle limit: generous against 1100 items with random stall bursts on each side
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("[half_bfloat_single_converter] ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, always ready near the end
  initial begin
    int burst;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (sent < quiet_from && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 17);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // operand biased toward exponent edges of half and single
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[30:23] = 8'(127 + $signed($urandom_range(0, 44)) - 28);
      1: v[30:23] = ($urandom_range(0, 1)) ? 8'hff : 8'h00;
      2: v[14:10] = ($urandom_range(0, 1)) ? 5'h1f : 5'h00;
      3: v = 32'hffff_0000 | $urandom_range(0, 32'hffff);
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_item(hbsc_pkg::op_t op, logic [31:0] v);
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.operand_bits <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic maybe_idle();
    if (sent < quiet_from && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  initial begin
    logic [31:0] corners[$];
    int          wait_cycles;
    cycles = 0;
    sent = 0;
    quiet_from = 1000;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = hbsc_pkg::OP_HALF_TO_SINGLE;
    in_ch.operand_bits = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: zero, subnormals, inf, NaN, range edges, wrap
    corners = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h0000_83ff,
                32'h0000_7c00, 32'h0000_fe01, 32'h7f80_0000, 32'hff80_0001,
                32'h477f_e000, 32'h4780_0000, 32'h3300_0000, 32'hb2ff_ffff,
                32'h3880_0000, 32'h387f_ffff, 32'h0040_0000, 32'h3f80_8000,
                32'h3f81_8000, 32'h7fff_ffff};
    foreach (corners[i]) begin
      send_item(hbsc_pkg::op_t'(i % 4), corners[i]);
      send_item(hbsc_pkg::op_t'((i + 1) % 4), corners[i]);
    end

    // random part, with one full drain in the middle
    while (sent < 1100) begin
      if (sent == 500) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      maybe_idle();
      send_item(hbsc_pkg::op_t'($urandom_range(0, 3)), pick_operand());
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 10) begin
      @(posedge clk);
      wait_cycles++;
    end

    $display("covered %0d items over all four conversions, incl. subnormal,", sent);
    $display("overflow, NaN and rounding-wrap operands under random stalls");
    if (mismatches == 0) begin
      $display("[half_bfloat_single_converter] OK");
    end else begin
      $display("[half_bfloat_single_converter] ERROR");
    end
    $finish;
  end
endmodule
